// ===== sv/skv_pkg.sv =====
package skv_pkg;

    localparam int MAX_SLOTS_DEF = 32;
    localparam int IDX_W         = 6;
    localparam int SCORE_W       = 32;
    localparam int RET_W         = 23;
    localparam int QUO_W         = 22;
    localparam int CNT_W         = 32;
    localparam int Q16_SHIFT     = 16;

    localparam logic [IDX_W-1:0] CAP_RESET    = 6'd32;
    localparam logic [IDX_W-1:0] MIN_INTERIOR = 6'd3;

    typedef enum logic [2:0] {
        KIND_BEGIN  = 3'd0,
        KIND_COMMIT = 3'd1,
        KIND_EVICT  = 3'd2,
        KIND_WORST  = 3'd3,
        KIND_PRUNE  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

endpackage

// ===== sv/skv_in_if.sv =====
interface skv_in_if;
    import skv_pkg::*;

    logic                valid;
    logic                ready;
    logic [2:0]          kind;
    logic [IDX_W-1:0]    slot_index;
    logic signed [SCORE_W-1:0] score_value;
    logic signed [SCORE_W-1:0] prune_threshold;

    modport source (output valid, kind, slot_index, score_value, prune_threshold,
                    input ready);
    modport sink   (input valid, kind, slot_index, score_value, prune_threshold,
                    output ready);
endinterface

// ===== sv/skv_out_if.sv =====
interface skv_out_if;
    import skv_pkg::*;

    logic              valid;
    logic              ready;
    logic              is_eviction;
    logic [IDX_W-1:0]  evicted_index;
    logic              last;
    logic [1:0]        status;
    logic [IDX_W-1:0]  free_slot;
    logic [IDX_W-1:0]  pruned_count;
    logic [IDX_W-1:0]  occupancy_now;
    logic [RET_W-1:0]  retention_q16;
    logic [CNT_W-1:0]  evicted_total;
    logic [CNT_W-1:0]  tokens_seen_total;

    modport source (output valid, is_eviction, evicted_index, last, status, free_slot,
                    pruned_count, occupancy_now, retention_q16, evicted_total,
                    tokens_seen_total, input ready);
    modport sink   (input valid, is_eviction, evicted_index, last, status, free_slot,
                    pruned_count, occupancy_now, retention_q16, evicted_total,
                    tokens_seen_total, output ready);
endinterface

// ===== sv/score_ranked_kv_slot_evictor_top.sv =====
// Commit goes straight to the retention divider; evict-at adds a shift pass.
// Evict-worst and begin add one occupancy-length scan per eviction; prune
// reads one entry at a time, plus a shift pass per removed entry.
// Each result passes through the serial retention divider.
// One item is in flight at a time; input ready only while idle.
// Synchronous active-low reset clears occupancy, counters and control.
module score_ranked_kv_slot_evictor_top #(
    parameter int MAX_SLOTS = skv_pkg::MAX_SLOTS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [skv_pkg::IDX_W-1:0] i_cfg_wdata,
    skv_in_if.sink                  i_in,
    skv_out_if.source               o_out
);
    import skv_pkg::*;

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam logic [IDX_W:0] MAX_W = (IDX_W+1)'(MAX_SLOTS);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_BEGIN   = 10'b0000000010,
        S_SCAN    = 10'b0000000100,
        S_SHIFT   = 10'b0000001000,
        S_PRD     = 10'b0000010000,
        S_PCMP    = 10'b0000100000,
        S_DIVINIT = 10'b0001000000,
        S_DIV     = 10'b0010000000,
        S_EMIT    = 10'b0100000000,
        S_NEXT    = 10'b1000000000
    } t_state;

    logic [SCORE_W-1:0] mem [MAX_SLOTS];
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [AW-1:0]      mem_ra;
    logic [SCORE_W-1:0] mem_wd;
    logic [SCORE_W-1:0] r_rdata;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_cap;
    logic [IDX_W-1:0]   eff_cap;
    logic [2:0]         r_kind, n_kind;
    logic [SCORE_W-1:0] r_thr, n_thr;
    logic [IDX_W-1:0]   r_occ, n_occ;
    logic [CNT_W-1:0]   r_evtot, n_evtot;
    logic [CNT_W-1:0]   r_tktot, n_tktot;
    logic [1:0]         r_status, n_status;
    logic [IDX_W-1:0]   r_free, n_free;
    logic [IDX_W-1:0]   r_pruned, n_pruned;
    logic               r_last, n_last;
    logic [IDX_W-1:0]   r_rm_idx, n_rm_idx;
    logic [IDX_W-1:0]   r_ptr, n_ptr;
    logic               r_pend, n_pend;
    logic [AW-1:0]      r_pa, n_pa;
    logic [SCORE_W-1:0] r_best, n_best;
    logic [IDX_W-1:0]   r_w, n_w;
    logic [IDX_W-1:0]   r_i, n_i;
    logic [QUO_W-1:0]   r_quo, n_quo;
    logic [IDX_W-1:0]   r_rem, n_rem;
    logic [4:0]         r_cnt, n_cnt;

    logic               r_ovalid, n_ovalid;
    logic               r_o_ev, r_o_last;
    logic [IDX_W-1:0]   r_o_idx, r_o_free, r_o_pruned, r_o_occ;
    logic [1:0]         r_o_status;
    logic [RET_W-1:0]   r_o_ret;
    logic [CNT_W-1:0]   r_o_evtot, r_o_tktot;
    logic               load_out;

    logic               start_rm;
    logic [IDX_W-1:0]   rm_i;
    logic               go_sum;
    logic [IDX_W:0]     trial;

    assign eff_cap = ({1'b0, r_cap} > MAX_W) ? MAX_W[IDX_W-1:0] : r_cap;
    assign trial   = {r_rem, r_quo[QUO_W-1]};

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_thr    = r_thr;
        n_occ    = r_occ;
        n_evtot  = r_evtot;
        n_tktot  = r_tktot;
        n_status = r_status;
        n_free   = r_free;
        n_pruned = r_pruned;
        n_last   = r_last;
        n_rm_idx = r_rm_idx;
        n_ptr    = r_ptr;
        n_pend   = r_pend;
        n_pa     = r_pa;
        n_best   = r_best;
        n_w      = r_w;
        n_i      = r_i;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid && !o_out.ready;
        load_out = 1'b0;
        mem_we   = 1'b0;
        mem_wa   = '0;
        mem_wd   = '0;
        mem_ra   = '0;
        start_rm = 1'b0;
        rm_i     = '0;
        go_sum   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_kind   = i_in.kind;
                    n_thr    = i_in.prune_threshold;
                    n_status = ST_DONE;
                    n_free   = '0;
                    n_pruned = '0;
                    unique case (i_in.kind)
                        KIND_BEGIN: begin
                            n_state = S_BEGIN;
                        end
                        KIND_COMMIT: begin
                            if (i_in.slot_index == r_occ && i_in.slot_index < eff_cap) begin
                                mem_we  = 1'b1;
                                mem_wa  = i_in.slot_index[AW-1:0];
                                mem_wd  = i_in.score_value;
                                n_occ   = r_occ + 1'b1;
                                n_tktot = r_tktot + 1'b1;
                            end else begin
                                n_status = ST_INVALID;
                            end
                            go_sum = 1'b1;
                        end
                        KIND_EVICT: begin
                            if (i_in.slot_index < r_occ) begin
                                start_rm = 1'b1;
                                rm_i     = i_in.slot_index;
                            end else begin
                                n_status = ST_INVALID;
                                go_sum   = 1'b1;
                            end
                        end
                        KIND_WORST: begin
                            if (r_occ >= MIN_INTERIOR) begin
                                n_ptr   = 6'd1;
                                n_pend  = 1'b0;
                                n_state = S_SCAN;
                            end else begin
                                n_status = ST_INVALID;
                                go_sum   = 1'b1;
                            end
                        end
                        KIND_PRUNE: begin
                            if (r_occ >= MIN_INTERIOR) begin
                                n_i     = r_occ - 6'd2;
                                n_state = S_PRD;
                            end else begin
                                go_sum = 1'b1;
                            end
                        end
                        default: begin
                            n_status = ST_INVALID;
                            go_sum   = 1'b1;
                        end
                    endcase
                end
            end
            S_BEGIN: begin
                if (eff_cap != '0 && r_occ >= eff_cap) begin
                    if (r_occ >= MIN_INTERIOR) begin
                        n_ptr   = 6'd1;
                        n_pend  = 1'b0;
                        n_state = S_SCAN;
                    end else begin
                        start_rm = 1'b1;
                        rm_i     = '0;
                    end
                end else begin
                    if (r_occ >= eff_cap) begin
                        n_status = ST_FULL;
                    end else begin
                        n_free = r_occ;
                    end
                    go_sum = 1'b1;
                end
            end
            S_SCAN: begin
                if (r_pend) begin
                    if (r_pa == AW'(1) || $signed(r_rdata) > $signed(r_best)) begin
                        n_best = r_rdata;
                        n_w    = IDX_W'(r_pa);
                    end
                end
                if ({1'b0, r_ptr} + 7'd1 < {1'b0, r_occ}) begin
                    mem_ra = r_ptr[AW-1:0];
                    n_pend = 1'b1;
                    n_pa   = r_ptr[AW-1:0];
                    n_ptr  = r_ptr + 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        start_rm = 1'b1;
                        rm_i     = r_w;
                    end
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    mem_we = 1'b1;
                    mem_wa = r_pa;
                    mem_wd = r_rdata;
                end
                if (r_ptr < r_occ) begin
                    mem_ra = r_ptr[AW-1:0];
                    n_pend = 1'b1;
                    n_pa   = r_ptr[AW-1:0] - 1'b1;
                    n_ptr  = r_ptr + 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_occ   = r_occ - 1'b1;
                        n_evtot = r_evtot + 1'b1;
                        n_last  = 1'b0;
                        n_state = S_DIVINIT;
                    end
                end
            end
            S_PRD: begin
                mem_ra  = r_i[AW-1:0];
                n_state = S_PCMP;
            end
            S_PCMP: begin
                if ($signed(r_rdata) > $signed(r_thr)) begin
                    n_pruned = r_pruned + 1'b1;
                    start_rm = 1'b1;
                    rm_i     = r_i;
                end else if (r_i == 6'd1) begin
                    go_sum = 1'b1;
                end else begin
                    n_i     = r_i - 1'b1;
                    n_state = S_PRD;
                end
            end
            S_DIVINIT: begin
                n_quo   = {r_occ, Q16_SHIFT'(0)};
                n_rem   = '0;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (trial >= {1'b0, eff_cap}) begin
                    n_rem = IDX_W'(trial - {1'b0, eff_cap});
                    n_quo = {r_quo[QUO_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[IDX_W-1:0];
                    n_quo = {r_quo[QUO_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'(QUO_W-1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_ovalid || o_out.ready) begin
                    load_out = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = r_last ? S_IDLE : S_NEXT;
                end
            end
            S_NEXT: begin
                if (r_kind == KIND_BEGIN) begin
                    n_state = S_BEGIN;
                end else if (r_kind == KIND_PRUNE) begin
                    if (r_occ < MIN_INTERIOR || r_i == 6'd1) begin
                        go_sum = 1'b1;
                    end else begin
                        n_i     = r_i - 1'b1;
                        n_state = S_PRD;
                    end
                end else begin
                    go_sum = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (start_rm) begin
            n_rm_idx = rm_i;
            n_ptr    = rm_i + 1'b1;
            n_pend   = 1'b0;
            n_state  = S_SHIFT;
        end
        if (go_sum) begin
            n_last  = 1'b1;
            n_state = S_DIVINIT;
        end
    end

    assign i_in.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cap    <= CAP_RESET;
            r_occ    <= '0;
            r_evtot  <= '0;
            r_tktot  <= '0;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_occ    <= n_occ;
            r_evtot  <= n_evtot;
            r_tktot  <= n_tktot;
            r_ovalid <= n_ovalid;
            r_pend   <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_thr    <= n_thr;
        r_status <= n_status;
        r_free   <= n_free;
        r_pruned <= n_pruned;
        r_last   <= n_last;
        r_rm_idx <= n_rm_idx;
        r_ptr    <= n_ptr;
        r_pa     <= n_pa;
        r_best   <= n_best;
        r_w      <= n_w;
        r_i      <= n_i;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        if (load_out) begin
            r_o_ev     <= !r_last;
            r_o_last   <= r_last;
            r_o_idx    <= r_last ? '0 : r_rm_idx;
            r_o_status <= r_last ? r_status : ST_DONE;
            r_o_free   <= r_last ? r_free : '0;
            r_o_pruned <= r_last ? r_pruned : '0;
            r_o_occ    <= r_occ;
            r_o_ret    <= (eff_cap == '0) ? '0 : RET_W'(r_quo);
            r_o_evtot  <= r_evtot;
            r_o_tktot  <= r_tktot;
        end
    end

    assign o_out.valid             = r_ovalid;
    assign o_out.is_eviction       = r_o_ev;
    assign o_out.evicted_index     = r_o_idx;
    assign o_out.last              = r_o_last;
    assign o_out.status            = r_o_status;
    assign o_out.free_slot         = r_o_free;
    assign o_out.pruned_count      = r_o_pruned;
    assign o_out.occupancy_now     = r_o_occ;
    assign o_out.retention_q16     = r_o_ret;
    assign o_out.evicted_total     = r_o_evtot;
    assign o_out.tokens_seen_total = r_o_tktot;

endmodule

// ===== bench/skv_evictor_checker.sv =====
module skv_evictor_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [5:0]        i_cfg_wdata,
    skv_in_if                 in_ch,
    skv_out_if                out_ch,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_evictions_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import skv_pkg::*;

    typedef struct packed {
        logic        is_ev;
        logic [5:0]  idx;
        logic        last;
        logic [1:0]  status;
        logic [5:0]  free_slot;
        logic [5:0]  pruned;
        logic [5:0]  occ;
        logic [22:0] ret;
        logic [31:0] ev_total;
        logic [31:0] tok_total;
    } t_result;

    logic signed [31:0] scores [MAX_SLOTS_DEF];
    int unsigned        occ_m;
    logic [31:0]        ev_cnt;
    logic [31:0]        tok_cnt;
    logic [5:0]         cap_reg;
    t_result            expected_results [$];

    function automatic int unsigned capacity_eff();
        return (cap_reg > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : cap_reg;
    endfunction

    function automatic logic [22:0] retention_now();
        int unsigned c;
        c = capacity_eff();
        if (c == 0)
            return '0;
        return 23'((occ_m * 65536) / c);
    endfunction

    function automatic void push_result(logic is_ev, logic [5:0] idx, logic [1:0] st,
                                        logic [5:0] fs, logic [5:0] pr);
        t_result r;
        r.is_ev = is_ev;
        r.idx = idx;
        r.last = !is_ev;
        r.status = st;
        r.free_slot = fs;
        r.pruned = pr;
        r.occ = 6'(occ_m);
        r.ret = retention_now();
        r.ev_total = ev_cnt;
        r.tok_total = tok_cnt;
        expected_results.push_back(r);
    endfunction

    function automatic void remove_entry(int unsigned at);
        for (int unsigned i = at; i + 1 < occ_m; i++)
            scores[i] = scores[i + 1];
        occ_m--;
        ev_cnt++;
        push_result(1'b1, 6'(at), ST_DONE, '0, '0);
    endfunction

    function automatic int unsigned highest_interior();
        int unsigned w;
        w = 1;
        for (int unsigned i = 2; i + 1 < occ_m; i++)
            if (scores[i] > scores[w])
                w = i;
        return w;
    endfunction

    function automatic void predict_item(logic [2:0] kind, logic [5:0] idx,
                                         logic signed [31:0] sc, logic signed [31:0] thr);
        int unsigned cap;
        logic [1:0]  st;
        logic [5:0]  fs;
        logic [5:0]  pr;
        cap = capacity_eff();
        st = ST_DONE;
        fs = '0;
        pr = '0;
        case (kind)
            KIND_BEGIN: begin
                while (cap > 0 && occ_m >= cap) begin
                    if (occ_m >= MIN_INTERIOR)
                        remove_entry(highest_interior());
                    else
                        remove_entry(0);
                end
                if (occ_m >= cap)
                    st = ST_FULL;
                else
                    fs = 6'(occ_m);
            end
            KIND_COMMIT: begin
                if (idx == occ_m && idx < cap) begin
                    scores[idx] = sc;
                    occ_m++;
                    tok_cnt++;
                end else begin
                    st = ST_INVALID;
                end
            end
            KIND_EVICT: begin
                if (idx < occ_m)
                    remove_entry(idx);
                else
                    st = ST_INVALID;
            end
            KIND_WORST: begin
                if (occ_m >= MIN_INTERIOR)
                    remove_entry(highest_interior());
                else
                    st = ST_INVALID;
            end
            KIND_PRUNE: begin
                if (occ_m >= MIN_INTERIOR) begin
                    for (int i = int'(occ_m) - 2; i > 0; i--) begin
                        if (scores[i] > thr) begin
                            remove_entry(i);
                            pr++;
                            if (occ_m < MIN_INTERIOR)
                                break;
                        end
                    end
                end
            end
            default: st = ST_INVALID;
        endcase
        push_result(1'b0, '0, st, fs, pr);
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result exp_r;
        if (!i_rst_n) begin
            occ_m = 0;
            ev_cnt = '0;
            tok_cnt = '0;
            cap_reg = CAP_RESET;
            expected_results.delete();
            o_fail_count <= 0;
            o_evictions_seen <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we)
                cap_reg = i_cfg_wdata;
            if (in_ch.valid && in_ch.ready)
                predict_item(in_ch.kind, in_ch.slot_index, in_ch.score_value,
                             in_ch.prune_threshold);
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.is_eviction, out_ch.evicted_index, out_ch.last,
                        out_ch.status, out_ch.free_slot, out_ch.pruned_count,
                        out_ch.occupancy_now, out_ch.retention_q16, out_ch.evicted_total,
                        out_ch.tokens_seen_total};
                if (got.is_ev)
                    o_evictions_seen <= o_evictions_seen + 1;
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result transfer: %p", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        if (o_fail_count < 10)
                            $display("mismatch at %0t\n  exp %p\n  got %p", $realtime,
                                     exp_r, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= expected_results.size();
        end
    end
endmodule

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import skv_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [5:0] i_cfg_wdata;
    int         fail_count;
    int         pending;
    int         evictions_seen;
    int         idle_cycles;
    int         items_sent;
    bit         timed_out;

    skv_in_if  in_ch ();
    skv_out_if out_ch ();

    score_ranked_kv_slot_evictor_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    skv_evictor_checker u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_evictions_seen(evictions_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            int gap;
            gap = $urandom_range(0, 3);
            if ($urandom_range(0, 7) == 0)
                gap = 0;
            repeat (gap) begin
                out_ch.ready <= 1'b0;
                @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000 && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(logic [2:0] kind, logic [5:0] idx, logic [31:0] sc,
                             logic [31:0] thr);
        repeat ($urandom_range(0, 3)) @(posedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.kind <= kind;
        in_ch.slot_index <= idx;
        in_ch.score_value <= sc;
        in_ch.prune_threshold <= thr;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        in_ch.valid <= 1'b0;
        items_sent++;
        @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [5:0] cap);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_score();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($urandom_range(0, 7)) << 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic fill_commits(int count);
        for (int i = 0; i < count; i++)
            send_item(KIND_COMMIT, 6'(u_chk.occ_m), rand_score(), '0);
    endtask

    initial begin
        int          c;
        logic [5:0]  caps [6];
        in_ch.valid = 1'b0;
        in_ch.kind = '0;
        in_ch.slot_index = '0;
        in_ch.score_value = '0;
        in_ch.prune_threshold = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_rst_n = 1'b0;
        items_sent = 0;
        timed_out = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(KIND_WORST, 6'd0, '0, '0);
        send_item(KIND_PRUNE, 6'd0, '0, '0);
        send_item(KIND_EVICT, 6'd0, '0, '0);
        send_item(KIND_BEGIN, 6'd0, '0, '0);
        send_item(KIND_COMMIT, 6'd5, '0, '0);
        send_item(KIND_COMMIT, 6'd0, 32'h8000_0000, '0);
        send_item(KIND_COMMIT, 6'd1, 32'h7FFF_FFFF, '0);
        send_item(KIND_PRUNE, 6'd0, '0, 32'h8000_0000);
        send_item(KIND_COMMIT, 6'd2, 32'h0005_0000, '0);
        send_item(KIND_COMMIT, 6'd3, 32'h0005_0000, '0);
        send_item(KIND_COMMIT, 6'd4, 32'hFFFF_0000, '0);
        send_item(KIND_WORST, 6'd0, '0, '0);
        send_item(KIND_EVICT, 6'd63, '0, '0);
        send_item(KIND_EVICT, 6'd3, '0, '0);
        send_item(3'd5, 6'd0, '0, '0);
        send_item(3'd7, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(KIND_PRUNE, 6'd0, '0, 32'h7FFF_FFFF);
        send_item(KIND_PRUNE, 6'd0, '0, 32'h8000_0000);

        write_capacity(6'd2);
        fill_commits(3);
        send_item(KIND_BEGIN, 6'd0, '0, '0);
        write_capacity(6'd0);
        send_item(KIND_BEGIN, 6'd0, '0, '0);
        send_item(KIND_COMMIT, 6'(u_chk.occ_m), 32'h1234_5678, '0);

        caps = '{6'd63, 6'd5, 6'd32, 6'd1, 6'd40, 6'd17};
        for (int ph = 0; ph < 6; ph++) begin
            write_capacity(caps[ph]);
            for (int n = 0; n < 50; n++) begin
                c = $urandom_range(0, 99);
                if (c < 45)
                    send_item(KIND_COMMIT,
                              ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'(u_chk.occ_m),
                              rand_score(), $urandom);
                else if (c < 60)
                    send_item(KIND_BEGIN, 6'($urandom), $urandom, $urandom);
                else if (c < 72)
                    send_item(KIND_EVICT, 6'($urandom_range(0, u_chk.occ_m + 1)),
                              $urandom, $urandom);
                else if (c < 82)
                    send_item(KIND_WORST, 6'($urandom), $urandom, $urandom);
                else if (c < 95)
                    send_item(KIND_PRUNE, 6'($urandom), $urandom, rand_score());
                else
                    send_item(3'($urandom_range(5, 7)), 6'($urandom), $urandom, $urandom);
            end
        end

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("sent %0d items over several capacity settings, %0d eviction results",
                 items_sent, evictions_seen);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
